@@ hw/rtl/vario_climb_rate_classifier_defines.svh @@
// Assertion macros shared by the climb-rate classifier RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef VARIO_CLIMB_RATE_CLASSIFIER_DEFINES_SVH
`define VARIO_CLIMB_RATE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define VCRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define VCRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vcrc_pkg.sv @@
`timescale 1ns / 1ps

package vcrc_pkg;

    // Window storage
    localparam int WINDOW_DEPTH = 128;
    localparam int RING_AW      = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = 32 + CNT_W;

    // Field and register widths
    localparam int P_W      = 17;
    localparam int F_W      = 33;
    localparam int ALPHA_W  = 16;
    localparam int THR_W    = 31;
    localparam int EVERY_W  = 6;
    localparam int WLEN_W   = 8;
    localparam int SPEED_W  = 32;
    localparam int CLASS_W  = 3;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int PROD_W   = ALPHA_W + F_W + 2;

    // Serial divider for the window average
    localparam int DIV_DW   = (CNT_W > 4) ? CNT_W : 4;
    localparam int DIV_CW   = $clog2(SUM_W + 1);
    localparam int ALT_DEN  = 12;

    // floor(y / 3) is (y * ALT_RECIP) >> 33 for any 32-bit y; shift by 2 first for 12
    localparam logic [31:0] ALT_RECIP = 32'hAAAA_AAAB;

    // Register indexes
    localparam logic [2:0] REG_EMA_ALPHA    = 3'd0;
    localparam logic [2:0] REG_THRESH_SLOW  = 3'd1;
    localparam logic [2:0] REG_THRESH_FAST  = 3'd2;
    localparam logic [2:0] REG_REPORT_EVERY = 3'd3;
    localparam logic [2:0] REG_WINDOW_LEN   = 3'd4;

    // Register reset values
    localparam logic [ALPHA_W-1:0] RST_EMA_ALPHA    = 16'd3277;
    localparam logic [THR_W-1:0]   RST_THRESH_SLOW  = 31'd5243;
    localparam logic [THR_W-1:0]   RST_THRESH_FAST  = 31'd7864;
    localparam logic [EVERY_W-1:0] RST_REPORT_EVERY = 6'd30;
    localparam logic [WLEN_W-1:0]  RST_WINDOW_LEN   = 8'd100;

    // Climb classes
    localparam logic [CLASS_W-1:0] CLS_NONE      = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SLOW_UP   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_FAST_UP   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_SLOW_DOWN = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_FAST_DOWN = 3'd4;

    typedef struct packed {
        logic [ALPHA_W-1:0] ema_alpha;
        logic [THR_W-1:0]   thresh_slow;
        logic [THR_W-1:0]   thresh_fast;
        logic [EVERY_W-1:0] report_every;
        logic [WLEN_W-1:0]  window_len;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_UPD,
        ST_ALT_GO,
        ST_ALT_MUL,
        ST_ALT_WAIT,
        ST_DROP_CHK,
        ST_DROP_SUB,
        ST_PUSH,
        ST_COUNT,
        ST_AVG_WAIT,
        ST_REPORT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_first;
        logic mul;
        logic upd;
        logic div_alt;
        logic alt_mul;
        logic take_alt;
        logic drop_rd;
        logic drop_sub;
        logic push;
        logic count_step;
        logic div_avg;
        logic report;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic first_done;
        logic div_done;
        logic need_drop;
        logic report_due;
        logic out_free;
    } sts_t;

endpackage

@@ hw/rtl/vcrc_regs.sv @@
`timescale 1ns / 1ps

module vcrc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vcrc_pkg::PADDR_W-1:0] paddr,
    input  logic [vcrc_pkg::PDATA_W-1:0] pwdata,
    output logic [vcrc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output vcrc_pkg::cfg_t               cfg
);
    import vcrc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Decode register writes, drop bits above each register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_EMA_ALPHA:    cfg_next.ema_alpha    = pwdata[ALPHA_W-1:0];
                REG_THRESH_SLOW:  cfg_next.thresh_slow  = pwdata[THR_W-1:0];
                REG_THRESH_FAST:  cfg_next.thresh_fast  = pwdata[THR_W-1:0];
                REG_REPORT_EVERY: cfg_next.report_every = pwdata[EVERY_W-1:0];
                REG_WINDOW_LEN:   cfg_next.window_len   = pwdata[WLEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_alpha    <= RST_EMA_ALPHA;
            cfg_reg.thresh_slow  <= RST_THRESH_SLOW;
            cfg_reg.thresh_fast  <= RST_THRESH_FAST;
            cfg_reg.report_every <= RST_REPORT_EVERY;
            cfg_reg.window_len   <= RST_WINDOW_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (idx)
            REG_EMA_ALPHA:    prdata = PDATA_W'(cfg_reg.ema_alpha);
            REG_THRESH_SLOW:  prdata = PDATA_W'(cfg_reg.thresh_slow);
            REG_THRESH_FAST:  prdata = PDATA_W'(cfg_reg.thresh_fast);
            REG_REPORT_EVERY: prdata = PDATA_W'(cfg_reg.report_every);
            REG_WINDOW_LEN:   prdata = PDATA_W'(cfg_reg.window_len);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/vcrc_ctrl.sv @@
`timescale 1ns / 1ps

module vcrc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  vcrc_pkg::sts_t sts,
    output vcrc_pkg::cmd_t cmd
);
    import vcrc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Sequence one sample through filter, altitude, window and report
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FILT;
                end
            end
            ST_FILT:
            begin
                if (!sts.first_done)
                begin
                    cmd.load_first = 1'b1;
                    state_next     = ST_ALT_GO;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_ALT_GO;
            end
            ST_ALT_GO:
            begin
                cmd.div_alt = 1'b1;
                state_next  = ST_ALT_MUL;
            end
            ST_ALT_MUL:
            begin
                cmd.alt_mul = 1'b1;
                state_next  = ST_ALT_WAIT;
            end
            ST_ALT_WAIT:
            begin
                cmd.take_alt = 1'b1;
                state_next   = ST_DROP_CHK;
            end
            ST_DROP_CHK:
            begin
                if (sts.need_drop)
                begin
                    cmd.drop_rd = 1'b1;
                    state_next  = ST_DROP_SUB;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_DROP_SUB:
            begin
                cmd.drop_sub = 1'b1;
                state_next   = ST_DROP_CHK;
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (sts.report_due)
                begin
                    cmd.div_avg = 1'b1;
                    state_next  = ST_AVG_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AVG_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/vcrc_div.sv @@
`timescale 1ns / 1ps

module vcrc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vcrc_pkg::SUM_W-1:0]  num,
    input  logic [vcrc_pkg::DIV_DW-1:0] den,
    output logic                        busy,
    output logic                        done,
    output logic [vcrc_pkg::SUM_W-1:0]  quot
);
    import vcrc_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [DIV_CW-1:0] iter_reg;
    logic [DIV_CW-1:0] iter_next;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] rem_next;
    logic [SUM_W-1:0]  quot_reg;
    logic [SUM_W-1:0]  quot_next;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] den_next;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_dif;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_dif = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            iter_next = DIV_CW'(SUM_W);
            rem_next  = '0;
            quot_next = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_dif[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            quot_next = {quot_reg[SUM_W-2:0], fits};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hw/rtl/vcrc_dpath.sv @@
`timescale 1ns / 1ps
`include "vario_climb_rate_classifier_defines.svh"

module vcrc_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vcrc_pkg::cfg_t                      cfg,
    input  vcrc_pkg::cmd_t                      cmd,
    output vcrc_pkg::sts_t                      sts,
    input  logic [vcrc_pkg::P_W-1:0]            pressure_pa,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vcrc_pkg::SPEED_W-1:0] climb_speed,
    output logic [vcrc_pkg::CLASS_W-1:0]        climb_class
);
    import vcrc_pkg::*;

    // Filter and reference
    logic [F_W-1:0]           p_reg;
    logic [F_W-1:0]           f_reg;
    logic [F_W-1:0]           ref_reg;
    logic                     first_reg;
    logic signed [F_W:0]      diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] step;
    logic [F_W-1:0]           f_upd;

    // Altitude and divider operands and result
    logic signed [F_W:0]      adiff;
    logic [F_W:0]             amag;
    logic [SUM_W-1:0]         smag;
    logic [F_W:0]             num_alt;
    logic [31:0]              alt_q4_reg;
    logic [63:0]              alt_prod_reg;
    logic [31:0]              alt_mag;
    logic [SUM_W-1:0]         num_avg;
    logic [SUM_W-1:0]         div_num;
    logic [DIV_DW-1:0]        div_den;
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quot;
    logic [SUM_W-1:0]         qs;
    logic [31:0]              val32;
    logic                     neg_reg;
    logic signed [31:0]       alt_reg;

    // Window ring
    logic [31:0]              ring_mem [WINDOW_DEPTH];
    logic [31:0]              rd_data_reg;
    logic [RING_AW-1:0]       head_reg;
    logic [RING_AW-1:0]       head_inc;
    logic [CNT_W-1:0]         count_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [RING_AW:0]         wsum;
    logic [RING_AW-1:0]       wr_addr;
    logic [31:0]              len32;
    logic                     need_drop;

    // Report interval
    logic [EVERY_W-1:0]       cnt_reg;
    logic [EVERY_W-1:0]       every;
    logic [EVERY_W:0]         cnt_inc;
    logic                     report_due;

    // Speed and class
    logic signed [31:0]       prev_reg;
    logic signed [32:0]       speed33;
    logic signed [31:0]       speed_sat;
    logic signed [33:0]       s34;
    logic signed [33:0]       slow34;
    logic signed [33:0]       fast34;
    logic [CLASS_W-1:0]       cls;
    logic                     out_valid_reg;
    logic signed [31:0]       speed_reg;
    logic [CLASS_W-1:0]       class_reg;
    logic                     out_free;

    // Smoothing step: f + floor((alpha * (p - f) + 32768) / 65536)
    assign diff     = $signed({1'b0, p_reg}) - $signed({1'b0, f_reg});
    assign prod     = PROD_W'($signed({1'b0, cfg.ema_alpha})) * PROD_W'(diff);
    assign prod_rnd = prod_reg + PROD_W'(32768);
    assign step     = prod_rnd >>> 16;
    assign f_upd    = f_reg + step[F_W-1:0];

    // Altitude: magnitude plus six, divide by four, then multiply by one third
    assign adiff   = $signed({1'b0, ref_reg}) - $signed({1'b0, f_reg});
    assign amag    = adiff[F_W] ? (~adiff + 1'b1) : adiff;
    assign num_alt = amag + (F_W + 1)'(ALT_DEN / 2);
    assign alt_mag = {1'b0, alt_prod_reg[63:33]};

    // Average divider operands: magnitude plus half the divisor, sign kept aside
    assign smag    = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign num_avg = smag + SUM_W'(count_reg >> 1);
    assign div_num = num_avg;
    assign div_den = DIV_DW'(count_reg);
    assign div_start = cmd.div_avg;
    assign qs      = neg_reg ? (~div_quot + 1'b1) : div_quot;
    assign val32   = qs[31:0];

    vcrc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Effective window length, clamped to [1, depth]
    always_comb
    begin
        if (cfg.window_len == '0)
            len32 = 32'd1;
        else if (32'(cfg.window_len) > WINDOW_DEPTH)
            len32 = WINDOW_DEPTH;
        else
            len32 = 32'(cfg.window_len);
    end

    assign need_drop = (32'(count_reg) >= len32) && (count_reg != '0);
    assign head_inc  = (head_reg == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wsum      = (RING_AW + 1)'(head_reg) + (RING_AW + 1)'(count_reg);
    assign wr_addr   = (wsum >= (RING_AW + 1)'(WINDOW_DEPTH))
                     ? RING_AW'(wsum - (RING_AW + 1)'(WINDOW_DEPTH))
                     : wsum[RING_AW-1:0];

    // Report interval, zero counts as one
    assign every      = (cfg.report_every == '0) ? EVERY_W'(1) : cfg.report_every;
    assign cnt_inc    = {1'b0, cnt_reg} + 1'b1;
    assign report_due = (cnt_inc >= {1'b0, every});

    // Speed with saturation, then strict threshold classes
    assign speed33 = {val32[31], val32} - {prev_reg[31], prev_reg};
    always_comb
    begin
        if (speed33[32] != speed33[31])
            speed_sat = speed33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            speed_sat = speed33[31:0];
    end

    assign s34    = {{2{speed_sat[31]}}, speed_sat};
    assign slow34 = {3'b000, cfg.thresh_slow};
    assign fast34 = {3'b000, cfg.thresh_fast};

    always_comb
    begin
        if ((s34 > slow34) && (s34 < fast34))
            cls = CLS_SLOW_UP;
        else if (s34 > fast34)
            cls = CLS_FAST_UP;
        else if ((s34 < -slow34) && (s34 > -fast34))
            cls = CLS_SLOW_DOWN;
        else if (s34 < -fast34)
            cls = CLS_FAST_DOWN;
        else
            cls = CLS_NONE;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_first)
                first_reg <= 1'b1;
            if (cmd.drop_sub)
            begin
                sum_reg   <= sum_reg - {{(SUM_W-32){rd_data_reg[31]}}, rd_data_reg};
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.push)
            begin
                sum_reg   <= sum_reg + {{(SUM_W-32){alt_reg[31]}}, alt_reg};
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.count_step)
                cnt_reg <= report_due ? '0 : cnt_inc[EVERY_W-1:0];
            if (cmd.report)
                prev_reg <= val32;
            // Hold the result until the receiver takes it
            if (cmd.report)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            p_reg <= {pressure_pa, 16'b0};
        if (cmd.load_first)
        begin
            f_reg   <= p_reg;
            ref_reg <= p_reg;
        end
        else if (cmd.upd)
        begin
            f_reg <= f_upd;
        end
        if (cmd.mul)
            prod_reg <= prod;
        if (cmd.div_alt)
        begin
            neg_reg    <= adiff[F_W];
            alt_q4_reg <= num_alt[F_W:2];
        end
        else if (cmd.div_avg)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.alt_mul)
            alt_prod_reg <= 64'(alt_q4_reg) * 64'(ALT_RECIP);
        if (cmd.take_alt)
            alt_reg <= neg_reg ? (~alt_mag + 1'b1) : alt_mag;
        if (cmd.report)
        begin
            speed_reg <= speed_sat;
            class_reg <= cls;
        end
    end

    // Ring memory, registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            ring_mem[wr_addr] <= alt_reg;
        if (cmd.drop_rd)
            rd_data_reg <= ring_mem[head_reg];
    end

    assign sts.first_done = first_reg;
    assign sts.div_done   = div_done;
    assign sts.need_drop  = need_drop;
    assign sts.report_due = report_due;
    assign sts.out_free   = out_free;

    assign out_valid   = out_valid_reg;
    assign climb_speed = speed_reg;
    assign climb_class = class_reg;

    `VCRC_ASSERT_IMP(a_push_has_room, cmd.push, !need_drop, "push into a full window")
    `VCRC_ASSERT_IMP(a_div_idle_at_start, div_start, !div_busy, "divider restarted while busy")
    `VCRC_ASSERT_IMP(a_report_after_done, cmd.report, div_done, "report before average quotient")
    `VCRC_ASSERT_NXT(a_push_fills, cmd.push, count_reg != '0, "window empty after push")
    `VCRC_ASSERT_IMP(a_report_has_room, cmd.report, out_free, "result overwrote pending result")

endmodule

@@ hw/rtl/vario_climb_rate_classifier.sv @@
`timescale 1ns / 1ps
// Variometer climb-rate classifier.
// Input channel: one pressure sample (pascals) per transfer on in_valid/in_stall.
// Output channel: climb_speed (signed Q15.16 m) and climb_class on out_valid/out_stall,
// one transfer every report_every samples, none for the other samples.
// Configuration: APB write/read of ema_alpha, thresh_slow, thresh_fast,
// report_every and window_len at byte addresses 0, 4, 8, 12, 16; write only while idle.
// Flow: one sample at a time. A sample passes through capture, the filter update (skipped
// for the first sample, which loads the filter), the altitude divide by 12, which is a shift
// and a registered reciprocal multiply, one drop step for each window entry dropped, and
// the push into the window. A reporting sample then waits for the 40-step serial divider
// that forms the window average (sum over fill count) before its result is registered.
// Reset clears the filter, the window fill and sum, the report counter and the
// previous average, and loads the register defaults; the ring memory needs no clear.
// A stalled result stays in the output register; the next sample is still accepted
// and processed, and only a further report waits until the pending one is taken.

module vario_climb_rate_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vcrc_pkg::PADDR_W-1:0]        paddr,
    input  logic [vcrc_pkg::PDATA_W-1:0]        pwdata,
    output logic [vcrc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [vcrc_pkg::P_W-1:0]            pressure_pa,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [vcrc_pkg::SPEED_W-1:0] climb_speed,
    output logic [vcrc_pkg::CLASS_W-1:0]        climb_class
);
    import vcrc_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    vcrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vcrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vcrc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .pressure_pa (pressure_pa),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .climb_speed (climb_speed),
        .climb_class (climb_class)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import vcrc_pkg::*;

    localparam int     SETTLE_CYCLES = 600;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     SAMPLE_TARGET = 1650;
    localparam int     IDLE_PCT      = 14;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     P_MAX         = 131071;
    localparam int     ALT_DIVISOR   = 12;
    localparam longint SPEED_MAX     = 64'sd2147483647;
    localparam longint SPEED_MIN     = -64'sd2147483648;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [CLASS_W-1:0]        cls;
    } climb_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [P_W-1:0]             pressure_pa = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SPEED_W-1:0]  climb_speed;
    logic [CLASS_W-1:0]         climb_class;

    // Register mirror
    logic [ALPHA_W-1:0]  cfg_alpha = RST_EMA_ALPHA;
    logic [THR_W-1:0]    cfg_slow  = RST_THRESH_SLOW;
    logic [THR_W-1:0]    cfg_fast  = RST_THRESH_FAST;
    logic [EVERY_W-1:0]  cfg_every = RST_REPORT_EVERY;
    logic [WLEN_W-1:0]   cfg_wlen  = RST_WINDOW_LEN;

    // Altitude tracking state
    longint filt_q16 = 0;
    longint ref_q16 = 0;
    bit     seeded = 1'b0;
    int     alt_ring [WINDOW_DEPTH];
    int     ring_head = 0;
    int     ring_fill = 0;
    longint ring_total = 0;
    int     report_ctr = 0;
    int     last_average = 0;

    climb_t pending_climbs [$];
    int     mismatches = 0;
    int     samples_sent = 0;
    int     cycle_count = 0;
    bit     quiet = 1'b0;
    int     hold_ask = 0;
    int     hold_left = 0;

    vario_climb_rate_classifier u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pressure_pa (pressure_pa),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .climb_speed (climb_speed),
        .climb_class (climb_class)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // Round to nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic void mirror_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        case (idx)
            REG_EMA_ALPHA:    cfg_alpha = val[ALPHA_W-1:0];
            REG_THRESH_SLOW:  cfg_slow  = val[THR_W-1:0];
            REG_THRESH_FAST:  cfg_fast  = val[THR_W-1:0];
            REG_REPORT_EVERY: cfg_every = val[EVERY_W-1:0];
            REG_WINDOW_LEN:   cfg_wlen  = val[WLEN_W-1:0];
            default:          ;
        endcase
    endfunction

    function automatic logic [PDATA_W-1:0] reg_value(input logic [2:0] idx);
        case (idx)
            REG_EMA_ALPHA:    return PDATA_W'(cfg_alpha);
            REG_THRESH_SLOW:  return PDATA_W'(cfg_slow);
            REG_THRESH_FAST:  return PDATA_W'(cfg_fast);
            REG_REPORT_EVERY: return PDATA_W'(cfg_every);
            REG_WINDOW_LEN:   return PDATA_W'(cfg_wlen);
            default:          return '0;
        endcase
    endfunction

    // Filter, push altitude, and queue a climb report when one is due
    task automatic predict_climb(input logic [P_W-1:0] p);
        longint ps;
        longint alt;
        longint avg;
        longint speed;
        longint slow;
        longint fast;
        int     lim;
        int     every;
        climb_t r;
        ps = longint'(p) << 16;
        if (!seeded)
        begin
            filt_q16 = ps;
            ref_q16 = ps;
            seeded = 1'b1;
        end
        else
            filt_q16 += (longint'(cfg_alpha) * (ps - filt_q16) + 32768) >>> 16;

        alt = round_div(ref_q16 - filt_q16, ALT_DIVISOR);

        // Drop oldest entries until one slot is free
        lim = (cfg_wlen == 0) ? 1 : int'(cfg_wlen);
        if (lim > WINDOW_DEPTH)
            lim = WINDOW_DEPTH;
        while (ring_fill >= lim && ring_fill > 0)
        begin
            ring_total -= alt_ring[ring_head];
            ring_head = (ring_head + 1) % WINDOW_DEPTH;
            ring_fill--;
        end
        alt_ring[(ring_head + ring_fill) % WINDOW_DEPTH] = int'(alt);
        ring_fill++;
        ring_total += alt;

        every = (cfg_every == 0) ? 1 : int'(cfg_every);
        if (report_ctr + 1 < every)
        begin
            report_ctr = (report_ctr + 1) % 64;
            return;
        end
        report_ctr = 0;

        avg = round_div(ring_total, longint'(ring_fill));
        speed = avg - longint'(last_average);
        if (speed > SPEED_MAX)
            speed = SPEED_MAX;
        if (speed < SPEED_MIN)
            speed = SPEED_MIN;
        last_average = int'(avg);

        slow = longint'(cfg_slow);
        fast = longint'(cfg_fast);
        if (speed > slow && speed < fast)
            r.cls = CLS_SLOW_UP;
        else if (speed > fast)
            r.cls = CLS_FAST_UP;
        else if (speed < -slow && speed > -fast)
            r.cls = CLS_SLOW_DOWN;
        else if (speed < -fast)
            r.cls = CLS_FAST_DOWN;
        else
            r.cls = CLS_NONE;
        r.speed = speed[SPEED_W-1:0];
        pending_climbs.push_back(r);
    endtask

    function automatic int idle_gap();
        int n = 0;
        if (quiet)
            return 0;
        while ($urandom_range(0, 99) < IDLE_PCT)
            n++;
        return n;
    endfunction

    // Offer one sample and hold it until the transfer
    task automatic send_sample(input logic [P_W-1:0] p);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pressure_pa <= p;
        do
            @(posedge clk);
        while (in_stall);
        predict_climb(p);
        samples_sent++;
    endtask

    // Stop offering, wait for every report, then let a silent sample finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_climbs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mirror_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read(input logic [2:0] idx, output logic [PDATA_W-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b0;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        val = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        logic [PDATA_W-1:0] got;
        for (int i = int'(REG_EMA_ALPHA); i <= int'(REG_WINDOW_LEN); i++)
        begin
            reg_read(3'(i), got);
            if (got !== reg_value(3'(i)))
                flag_mismatch($sformatf("register %0d read %0h, expected %0h",
                                        i, got, reg_value(3'(i))));
        end
    endtask

    task automatic set_regs(input logic [PDATA_W-1:0] alpha, input logic [PDATA_W-1:0] slow,
                            input logic [PDATA_W-1:0] fast, input logic [PDATA_W-1:0] every,
                            input logic [PDATA_W-1:0] wlen);
        reg_write(REG_EMA_ALPHA, alpha);
        reg_write(REG_THRESH_SLOW, slow);
        reg_write(REG_THRESH_FAST, fast);
        reg_write(REG_REPORT_EVERY, every);
        reg_write(REG_WINDOW_LEN, wlen);
    endtask

    // Stall the receiver for a fixed stretch when asked
    always @(posedge clk)
    begin
        if (hold_ask > 0)
        begin
            hold_left = hold_ask;
            hold_ask = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        climb_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_climbs.size() == 0)
                flag_mismatch($sformatf("unexpected result speed %0d class %0d",
                                        climb_speed, climb_class));
            else
            begin
                want = pending_climbs.pop_front();
                if (climb_speed !== want.speed || climb_class !== want.cls)
                    flag_mismatch($sformatf("speed exp %0d got %0d, class exp %0d got %0d",
                                            want.speed, climb_speed, want.cls, climb_class));
            end
        end
    end

    // Defaults, width masking and the unused address
    task automatic test_register_access();
        check_regs();
        set_regs('1, '1, '1, '1, '1);
        check_regs();
        reg_write(REG_UNUSED, $urandom());
        check_regs();
    endtask

    // First sample loads the filter; full-scale swings and zero pressure
    task automatic test_first_sample_extremes();
        set_regs(32'hFFFF, 0, 0, 1, 1);
        send_sample(P_W'(P_MAX));
        send_sample('0);
        send_sample(P_W'(P_MAX));
        send_sample('0);
        send_sample('0);
        send_sample('0);
        // settle to zero speed, which equals both thresholds
        repeat (3) send_sample(P_W'(77777));
        wait_drained();
    endtask

    // One step of each climb class, one meter is about twelve pascals
    task automatic test_climb_classes();
        set_regs(32'hFFFF, 65536, 4 * 65536, 1, 1);
        send_sample(P_W'(100000));
        send_sample(P_W'(100000));
        send_sample(P_W'(99976));
        send_sample(P_W'(99856));
        send_sample(P_W'(99880));
        send_sample(P_W'(100000));
        wait_drained();
    endtask

    // Zero and oversized window, shrinking window, zero and lowered interval
    task automatic test_window_limits();
        set_regs(RST_EMA_ALPHA, RST_THRESH_SLOW, RST_THRESH_FAST, 0, 0);
        send_sample(P_W'(101325));
        send_sample(P_W'(101300));
        wait_drained();
        reg_write(REG_WINDOW_LEN, 255);
        send_sample(P_W'(101280));
        send_sample(P_W'(101250));
        wait_drained();
        reg_write(REG_WINDOW_LEN, 1);
        send_sample(P_W'(101270));
        wait_drained();
        reg_write(REG_REPORT_EVERY, 40);
        repeat (4) send_sample(P_W'($urandom_range(101000, 101400)));
        wait_drained();
        reg_write(REG_REPORT_EVERY, 2);
        send_sample(P_W'(101200));
        wait_drained();
    endtask

    // Hold results off long enough that the block stalls its input
    task automatic test_output_backpressure();
        set_regs($urandom_range(1000, 20000), 30000, 90000, 1, 8);
        hold_ask = HOLD_CYCLES;
        repeat (60) send_sample(P_W'($urandom_range(100000, 101000)));
        wait_drained();
    endtask

    task automatic pick_flight_regs(input int phase);
        logic [PDATA_W-1:0] alpha;
        logic [PDATA_W-1:0] slow;
        logic [PDATA_W-1:0] fast;
        logic [PDATA_W-1:0] every;
        logic [PDATA_W-1:0] wlen;
        if (phase == 0)
            set_regs(32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63, WINDOW_DEPTH);
        else if (phase == 1)
            set_regs(0, 0, 0, 1, 1);
        else
        begin
            alpha = ($urandom_range(0, 1)) ? $urandom_range(1000, 20000)
                                           : $urandom_range(0, 32'hFFFF);
            if ($urandom_range(0, 9) == 0)
            begin
                slow = $urandom_range(0, 32'h7FFF_FFFF);
                fast = $urandom_range(0, 32'h7FFF_FFFF);
            end
            else
            begin
                slow = $urandom_range(0, 131072);
                fast = slow + $urandom_range(0, 262144);
            end
            every = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
            wlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
            set_regs(alpha, slow, fast, every, wlen);
        end
    endtask

    // Drifting altitude walks with occasional full-range noise samples
    task automatic test_random_flight();
        int             phase;
        int             level;
        int             drift;
        int             jitter;
        int             n;
        logic [P_W-1:0] p;
        phase = 0;
        level = 101325;
        while (samples_sent < SAMPLE_TARGET)
        begin
            pick_flight_regs(phase);
            quiet = (phase == 3);
            n = $urandom_range(20, 120);
            drift = $urandom_range(0, 60) - 30;
            jitter = $urandom_range(0, 40);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 12)
                    p = P_W'($urandom_range(0, P_MAX));
                else
                begin
                    level = level + drift + $urandom_range(0, 2 * jitter) - jitter;
                    if (level < 0)
                        level = 0;
                    if (level > P_MAX)
                        level = P_MAX;
                    p = P_W'(level);
                end
                send_sample(p);
            end
            wait_drained();
            quiet = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_first_sample_extremes();
        test_climb_classes();
        test_window_limits();
        test_output_backpressure();
        test_random_flight();
        if (mismatches == 0 && pending_climbs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/vcrc_pkg.sv
hw/rtl/vcrc_regs.sv
hw/rtl/vcrc_ctrl.sv
hw/rtl/vcrc_div.sv
hw/rtl/vcrc_dpath.sv
hw/rtl/vario_climb_rate_classifier.sv
bench/testbench.sv
